// ===== hdl/timestamped_telemetry_ring_lookup_unit_macros.svh =====
// assertion macros for the telemetry ring lookup unit checker
// depends on nothing; included by the checker file
`ifndef TIMESTAMPED_TELEMETRY_RING_LOOKUP_UNIT_MACROS_SVH
`define TIMESTAMPED_TELEMETRY_RING_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication
`define TTRL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttrl check failed");

// next-cycle implication
`define TTRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttrl check failed");

`endif

// ===== hdl/ttrl_pkg.sv =====
// shared types, sizes and codes for the telemetry ring lookup unit
// no dependencies
package ttrl_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = AW + 2;

  localparam logic [1:0] ST_EXACT   = 2'd0;
  localparam logic [1:0] ST_MID     = 2'd1;
  localparam logic [1:0] ST_WAIT    = 2'd2;
  localparam logic [1:0] ST_DISCARD = 2'd3;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [30:0] lat;
    logic [31:0] lon;
    logic [31:0] alt;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
  } rec_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] stamp;
    rec_t        rec;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] stamp;
    rec_t        rec;
  } result_t;

  function automatic logic [15:0] avg16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    return s[16:1];
  endfunction

  function automatic logic [31:0] avg32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  function automatic rec_t rec_avg(rec_t a, rec_t b);
    rec_t        r;
    logic [31:0] s;
    s       = {a.lat[30], a.lat} + {b.lat[30], b.lat};
    r.lat   = s[31:1];
    r.lon   = avg32(a.lon, b.lon);
    r.alt   = avg32(a.alt, b.alt);
    r.vx    = avg16(a.vx, b.vx);
    r.vy    = avg16(a.vy, b.vy);
    r.vz    = avg16(a.vz, b.vz);
    r.roll  = avg16(a.roll, b.roll);
    r.pitch = avg16(a.pitch, b.pitch);
    r.yaw   = avg16(a.yaw, b.yaw);
    return r;
  endfunction

endpackage

// ===== hdl/ttrl_front.sv =====
// front end: takes input transfers and queues decoded items in a two-entry queue
// depends on ttrl_pkg
module ttrl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ttrl_pkg::item_t in_item,
  output logic           q_valid,
  output ttrl_pkg::item_t q_item,
  input  logic           q_pop
);
  import ttrl_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/ttrl_back.sv =====
// back end: ring store, time bounds, binary search and result register
// depends on ttrl_pkg
module ttrl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ttrl_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              res_valid,
  output ttrl_pkg::result_t res,
  input  logic              res_ready
);
  import ttrl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OLD  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DA   = 3'd5;
  localparam logic [2:0] S_DB   = 3'd6;

  logic [31:0] stamp_a_mem [DEPTH];
  logic [31:0] stamp_b_mem [DEPTH];
  rec_t        data_mem    [DEPTH];

  logic [2:0]           state;
  logic [AW-1:0]        wp;
  logic                 wrapped;
  logic [31:0]          newest;
  logic [31:0]          oldest;
  logic [31:0]          wrap_start;
  logic [DEPTH-1:0]     valid;
  logic signed [SW-1:0] s;
  logic signed [SW-1:0] e;
  logic [AW-1:0]        ra;
  logic [AW-1:0]        rb;
  logic [31:0]          cur_t;
  logic                 midp;
  logic                 use_b;
  rec_t                 rec_a;

  logic [31:0] ta_raw;
  logic [31:0] tb_raw;
  rec_t        d_raw;
  logic        va_q;
  logic        vb_q;
  logic        dv_q;

  logic          we;
  logic [AW-1:0] sa_addr;
  logic [AW-1:0] sb_addr;
  logic [AW-1:0] d_addr;
  logic [AW-1:0] wp_inc;
  logic [SW-1:0] sum;
  logic [AW-1:0] mid;
  logic [AW-1:0] mid_nb;
  logic [31:0]   ta;
  logic [31:0]   tb;
  rec_t          d_val;
  logic [31:0]   t_in;

  assign t_in   = q_item.stamp;
  assign wp_inc = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign sum    = s + e;
  assign mid    = sum[AW:1];
  assign mid_nb = (mid == AW'(DEPTH - 1)) ? '0 : mid + 1'b1;
  assign ta     = va_q ? ta_raw : '0;
  assign tb     = vb_q ? tb_raw : '0;
  assign d_val  = dv_q ? d_raw : '0;

  always_comb begin
    we      = 1'b0;
    q_pop   = 1'b0;
    sa_addr = ra;
    sb_addr = rb;
    d_addr  = ra;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == KIND_STORE) begin
            we      = 1'b1;
            q_pop   = 1'b1;
            sa_addr = wp_inc;
          end else if (!res_valid) begin
            q_pop = 1'b1;
          end
        end
      end
      S_SRCH: begin
        sa_addr = mid;
        sb_addr = mid_nb;
      end
      S_DRD: d_addr = use_b ? rb : ra;
      S_DA: d_addr = rb;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stamp_a_mem[wp] <= t_in;
      stamp_b_mem[wp] <= t_in;
      data_mem[wp]    <= q_item.rec;
    end
    ta_raw <= stamp_a_mem[sa_addr];
    tb_raw <= stamp_b_mem[sb_addr];
    d_raw  <= data_mem[d_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      newest    <= '1;
      oldest    <= '0;
      wrap_start <= '0;
      valid     <= '0;
      res_valid <= 1'b0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      dv_q      <= 1'b0;
      s         <= '0;
      e         <= '0;
      ra        <= '0;
      rb        <= '0;
      midp      <= 1'b0;
      use_b     <= 1'b0;
    end else begin
      va_q <= valid[sa_addr];
      vb_q <= valid[sb_addr];
      dv_q <= valid[d_addr];
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_item.kind == KIND_STORE) begin
            newest    <= t_in;
            valid[wp] <= 1'b1;
            wp        <= wp_inc;
            if (wp == '0) wrap_start <= t_in;
            if (!wrapped && wp_inc == '0) oldest <= t_in;
            if (!wrapped && wp_inc == AW'(DEPTH - 1)) wrapped <= 1'b1;
            if (wrapped) state <= S_OLD;
          end else if (q_valid && !res_valid) begin
            cur_t <= t_in;
            if (t_in > newest) begin
              res       <= '{status: ST_WAIT, stamp: '0, rec: '0};
              res_valid <= 1'b1;
            end else if (t_in < oldest) begin
              res       <= '{status: ST_DISCARD, stamp: '0, rec: '0};
              res_valid <= 1'b1;
            end else begin
              if (wp == '0 || t_in < wrap_start) begin
                s <= SW'(wp);
                e <= SW'(DEPTH - 1);
              end else begin
                s <= '0;
                e <= SW'(wp) - SW'(1);
              end
              state <= S_SRCH;
            end
          end
        end
        S_OLD: begin
          oldest <= ta;
          state  <= S_IDLE;
        end
        S_SRCH: begin
          if (s <= e) begin
            ra    <= mid;
            rb    <= mid_nb;
            state <= S_CMP;
          end else begin
            res       <= '{status: ST_WAIT, stamp: '0, rec: '0};
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_CMP: begin
          if (cur_t == ta) begin
            midp  <= 1'b0;
            use_b <= 1'b0;
            state <= S_DRD;
          end else if (cur_t < ta) begin
            e     <= SW'(ra) - SW'(1);
            state <= S_SRCH;
          end else if (cur_t > tb) begin
            s     <= SW'(ra) + SW'(1);
            state <= S_SRCH;
          end else if (cur_t < tb) begin
            midp  <= 1'b1;
            use_b <= 1'b0;
            state <= S_DRD;
          end else begin
            midp  <= 1'b0;
            use_b <= 1'b1;
            state <= S_DRD;
          end
        end
        S_DRD: state <= S_DA;
        S_DA: begin
          rec_a <= d_val;
          if (midp) begin
            state <= S_DB;
          end else begin
            res       <= '{status: ST_EXACT, stamp: cur_t, rec: d_val};
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DB: begin
          res       <= '{status: ST_MID, stamp: cur_t, rec: rec_avg(rec_a, d_val)};
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/timestamped_telemetry_ring_lookup_unit.sv =====
// Telemetry ring store with lookup by time. A store transfer (tuser 0) writes
// one record into a 64-entry ring; once the ring has wrapped, the oldest
// stamp is also read back from the stamp memory. A query transfer (tuser 1)
// gives one result: wait and discard are decided in the idle state; exact or
// midpoint after a binary search (at most 7 probes, one registered read of
// the two stamp memories each) and one or two registered reads of the record
// memory; a search that finds no slot ends with a wait result. A two-entry
// queue sits between the input side and the search engine, and results wait
// in an output register.
// depends on ttrl_pkg, ttrl_front, ttrl_back
module timestamped_telemetry_ring_lookup_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // stamp, latitude, longitude, altitude, vel_x, vel_y, vel_z,
  // roll_angle, pitch_angle, yaw_angle, one pad bit
  input  logic [223:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, out_stamp, out_latitude, out_longitude, out_altitude, out_vel_x,
  // out_vel_y, out_vel_z, out_roll, out_pitch, out_yaw, seven pad bits
  output logic [231:0] m_tdata
);
  import ttrl_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  assign in_item.kind      = s_tuser;
  assign in_item.stamp     = s_tdata[31:0];
  assign in_item.rec.lat   = s_tdata[62:32];
  assign in_item.rec.lon   = s_tdata[94:63];
  assign in_item.rec.alt   = s_tdata[126:95];
  assign in_item.rec.vx    = s_tdata[142:127];
  assign in_item.rec.vy    = s_tdata[158:143];
  assign in_item.rec.vz    = s_tdata[174:159];
  assign in_item.rec.roll  = s_tdata[190:175];
  assign in_item.rec.pitch = s_tdata[206:191];
  assign in_item.rec.yaw   = s_tdata[222:207];

  ttrl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ttrl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tdata = {7'd0, res.rec.yaw, res.rec.pitch, res.rec.roll, res.rec.vz,
                    res.rec.vy, res.rec.vx, res.rec.alt, res.rec.lon, res.rec.lat,
                    res.stamp, res.status};

endmodule

// ===== hdl/ttrl_checker.sv =====
// port-level checks for the telemetry ring lookup unit, bound to the top level
// depends on ttrl_pkg and the macros header
`include "timestamped_telemetry_ring_lookup_unit_macros.svh"

module ttrl_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [223:0] s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [231:0] m_tdata
);
  import ttrl_pkg::*;

  logic stalled;
  logic in_stalled;
  logic no_data_status;

  assign stalled        = m_tvalid && !m_tready;
  assign in_stalled     = s_tvalid && !s_tready;
  assign no_data_status = (m_tdata[1:0] == ST_WAIT) || (m_tdata[1:0] == ST_DISCARD);

  `TTRL_ASSERT_NEXT(a_hold_valid, clk, rst, stalled, m_tvalid)
  `TTRL_ASSERT_NEXT(a_hold_data, clk, rst, stalled, $stable(m_tdata))
  `TTRL_ASSERT_NOW(a_reset_idle, clk, rst, $past(rst), !m_tvalid)
  `TTRL_ASSERT_NOW(a_empty_result, clk, rst, m_tvalid && no_data_status,
                   m_tdata[231:2] == '0)
  `TTRL_ASSERT_NEXT(a_in_hold, clk, rst, in_stalled,
                    s_tvalid && $stable(s_tdata) && $stable(s_tuser))

endmodule

bind timestamped_telemetry_ring_lookup_unit ttrl_checker u_ttrl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
